/* hdl/kcc_pkg.sv */
// Package for the key click classifier: state and event codes, register indexes,
// command struct and default sizes. Depends on nothing.
`timescale 1ns / 1ps
package kcc_pkg;

  // Default sizes
  localparam int NUM_KEYS_DEF   = 8;
  localparam int RING_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int KEY_W     = 3;
  localparam int TIME_W    = 16;
  localparam int STEP_W    = 8;
  localparam int PENDING_W = 3;

  // Per-key click state
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_MAYBE     = 3'd1,
    ST_PRESSED   = 3'd2,
    ST_LONG      = 3'd3,
    ST_MAYBE_DBL = 3'd4,
    ST_DOUBLE    = 3'd5
  } click_state_e;

  // Click events
  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } click_event_e;

  // Request opcodes
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TICK_STEP  = 2'd0,
    CFG_CONFIRM    = 2'd1,
    CFG_LONG_PRESS = 2'd2,
    CFG_DOUBLE_GAP = 2'd3
  } cfg_reg_e;

  // Configuration values seen by the back end
  typedef struct packed {
    logic [STEP_W-1:0] tick_step;
    logic [TIME_W-1:0] confirm_hold;
    logic [TIME_W-1:0] long_hold;
    logic [TIME_W-1:0] double_click_gap;
  } cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic             pop;
    logic             hit;
    logic [KEY_W-1:0] key;
    logic             down;
  } cmd_t;

endpackage

/* hdl/kcc_if.sv */
// Handshake channel interfaces for the key click classifier: request, result and
// configuration write. Depends on kcc_pkg.
`timescale 1ns / 1ps
interface kcc_req_if;
  logic                      valid;
  logic                      ready;
  kcc_pkg::opcode_e          opcode;
  logic [kcc_pkg::KEY_W-1:0] key_index;
  logic                      key_down;

  modport source (output valid, opcode, key_index, key_down, input ready);
  modport sink   (input valid, opcode, key_index, key_down, output ready);
endinterface

interface kcc_res_if;
  logic                          valid;
  logic                          ready;
  logic [kcc_pkg::KEY_W-1:0]     key_index_out;
  logic                          event_valid;
  logic [1:0]                    event_code;
  logic [kcc_pkg::PENDING_W-1:0] pending_count;
  logic [2:0]                    click_state;

  modport source (output valid, key_index_out, event_valid, event_code, pending_count,
                  click_state, input ready);
  modport sink   (input valid, key_index_out, event_valid, event_code, pending_count,
                  click_state, output ready);
endinterface

interface kcc_cfg_if;
  logic                       valid;
  logic                       ready;
  kcc_pkg::cfg_reg_e          index;
  logic [kcc_pkg::TIME_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/kcc_front.sv */
// Front end: accepts requests, classifies them into commands and queues them
// in a two-entry FIFO for the back end. Depends on kcc_pkg and kcc_if.
`timescale 1ns / 1ps
module kcc_front #(
  parameter int NUM_KEYS = kcc_pkg::NUM_KEYS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  kcc_req_if.sink         req,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output kcc_pkg::cmd_t   cmd_o
);

  kcc_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;
  kcc_pkg::cmd_t cmd_in;

  // Classify the incoming request
  always_comb begin
    cmd_in.pop  = (req.opcode == kcc_pkg::OP_POP);
    cmd_in.hit  = (int'(req.key_index) < NUM_KEYS);
    cmd_in.key  = req.key_index;
    cmd_in.down = req.key_down;
  end

  assign req.ready   = (count_q != 2'd2);
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* hdl/kcc_back.sv */
// Back end: runs one command per cycle unless its output register stalls, on the
// per-key click state and event rings, holding the result. Depends on kcc_pkg and kcc_if.
`timescale 1ns / 1ps
module kcc_back #(
  parameter int NUM_KEYS   = kcc_pkg::NUM_KEYS_DEF,
  parameter int RING_DEPTH = kcc_pkg::RING_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kcc_pkg::cfg_t   cfg_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  kcc_pkg::cmd_t   cmd_i,
  kcc_res_if.source       res
);

  // Keys beyond the index field are never addressed
  localparam int KEYS_USED = (NUM_KEYS < 8) ? NUM_KEYS : 8;
  localparam int KEY_AW    = (KEYS_USED > 1) ? $clog2(KEYS_USED) : 1;
  localparam int HEAD_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W     = HEAD_W + 1;
  localparam int FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int MEM_DEPTH = KEYS_USED * RING_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int TW        = kcc_pkg::TIME_W;

  // Per-key state
  kcc_pkg::click_state_e state_q [KEYS_USED];
  logic [TW-1:0]         hold_q  [KEYS_USED];
  logic [TW-1:0]         gap_q   [KEYS_USED];
  logic                  flag_q  [KEYS_USED];
  logic [HEAD_W-1:0]     head_q  [KEYS_USED];
  logic [FILL_W-1:0]     fill_q  [KEYS_USED];

  // Event ring memory
  logic [1:0]            ring_mem [MEM_DEPTH];
  logic [1:0]            rd_data_q;

  // Output register
  logic                          out_valid_q;
  logic [kcc_pkg::KEY_W-1:0]     out_key_q;
  logic                          out_ev_q;
  logic [kcc_pkg::PENDING_W-1:0] out_pend_q;
  logic [2:0]                    out_state_q;

  logic                  fire;
  logic [KEY_AW-1:0]     k_idx;
  kcc_pkg::click_state_e cur_st, n_st;
  logic [TW-1:0]         cur_hold, cur_gap, n_hold, n_gap;
  logic [TW:0]           hold_sum, gap_sum;
  logic [TW-1:0]         hold_add, gap_add;
  logic                  cur_flag, n_flag;
  logic [HEAD_W-1:0]     cur_head, n_head;
  logic [FILL_W-1:0]     cur_fill, n_fill;
  logic                  rec;
  kcc_pkg::click_event_e rec_ev;
  logic [SUM_W-1:0]      slot_sum;
  logic [HEAD_W-1:0]     slot;
  logic                  wr_en, rd_en, pop_hit;
  logic [MEM_AW-1:0]     wr_addr, rd_addr;

  assign cmd_ready_o = !out_valid_q || res.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign k_idx       = cmd_i.key[KEY_AW-1:0];

  assign cur_st   = state_q[k_idx];
  assign cur_hold = hold_q[k_idx];
  assign cur_gap  = gap_q[k_idx];
  assign cur_flag = flag_q[k_idx];
  assign cur_head = head_q[k_idx];
  assign cur_fill = fill_q[k_idx];

  // Saturating timer adds
  assign hold_sum = {1'b0, cur_hold} + (TW + 1)'(cfg_i.tick_step);
  assign gap_sum  = {1'b0, cur_gap} + (TW + 1)'(cfg_i.tick_step);
  assign hold_add = hold_sum[TW] ? {TW{1'b1}} : hold_sum[TW-1:0];
  assign gap_add  = gap_sum[TW] ? {TW{1'b1}} : gap_sum[TW-1:0];

  // Next click state per scan sample
  always_comb begin
    n_st   = cur_st;
    n_hold = cmd_i.down ? hold_add : cur_hold;
    n_gap  = cur_gap;
    n_flag = cur_flag;
    rec    = 1'b0;
    rec_ev = kcc_pkg::EV_SHORT;
    case (cur_st)
      kcc_pkg::ST_IDLE: begin
        if (!cmd_i.down) begin
          n_hold = '0;
        end else begin
          n_st = kcc_pkg::ST_MAYBE;
        end
      end
      kcc_pkg::ST_MAYBE: begin
        if (!cur_flag) begin
          if (!cmd_i.down) begin
            n_st = kcc_pkg::ST_IDLE;
          end else if (n_hold >= cfg_i.confirm_hold) begin
            n_st = kcc_pkg::ST_PRESSED;
          end
        end else begin
          if (!cmd_i.down) begin
            n_st   = kcc_pkg::ST_PRESSED;
            rec    = 1'b1;
            rec_ev = kcc_pkg::EV_SHORT;
          end else if (n_hold >= cfg_i.confirm_hold) begin
            n_st   = kcc_pkg::ST_DOUBLE;
            n_hold = '0;
            n_flag = 1'b0;
            rec    = 1'b1;
            rec_ev = kcc_pkg::EV_DOUBLE;
          end
        end
      end
      kcc_pkg::ST_PRESSED: begin
        if (!cmd_i.down) begin
          n_st   = kcc_pkg::ST_MAYBE_DBL;
          n_hold = '0;
          n_gap  = '0;
        end else if (n_hold >= cfg_i.long_hold) begin
          n_st = kcc_pkg::ST_LONG;
        end
      end
      kcc_pkg::ST_MAYBE_DBL: begin
        if (!cmd_i.down) begin
          n_gap = gap_add;
          if (gap_add >= cfg_i.double_click_gap) begin
            n_st   = kcc_pkg::ST_IDLE;
            n_hold = '0;
            n_gap  = '0;
            rec    = 1'b1;
            rec_ev = kcc_pkg::EV_SHORT;
          end
        end else begin
          n_st   = kcc_pkg::ST_MAYBE;
          n_flag = 1'b1;
        end
      end
      kcc_pkg::ST_DOUBLE: begin
        if (!cmd_i.down) begin
          n_st = kcc_pkg::ST_IDLE;
        end
      end
      kcc_pkg::ST_LONG: begin
        if (!cmd_i.down) begin
          n_st   = kcc_pkg::ST_IDLE;
          n_hold = '0;
          rec    = 1'b1;
          rec_ev = kcc_pkg::EV_LONG;
        end
      end
      default: begin
        n_st = cur_st;
      end
    endcase
  end

  // Ring slot for a new event: (head + fill) mod depth, sum stays below twice depth
  always_comb begin
    slot_sum = {1'b0, cur_head} + SUM_W'(cur_fill);
    if (slot_sum >= SUM_W'(RING_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(RING_DEPTH);
    end
    slot = slot_sum[HEAD_W-1:0];
  end

  // Ring bookkeeping for record and pop
  always_comb begin
    n_head  = cur_head;
    n_fill  = cur_fill;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    pop_hit = 1'b0;
    if (fire && cmd_i.hit) begin
      if (cmd_i.pop) begin
        if (cur_fill != '0) begin
          pop_hit = 1'b1;
          rd_en   = 1'b1;
          n_fill  = cur_fill - FILL_W'(1);
          n_head  = (cur_head == HEAD_W'(RING_DEPTH - 1)) ? '0 : cur_head + HEAD_W'(1);
        end
      end else if (rec && (cur_fill < FILL_W'(RING_DEPTH))) begin
        wr_en  = 1'b1;
        n_fill = cur_fill + FILL_W'(1);
      end
    end
  end

  assign wr_addr = MEM_AW'(int'(k_idx) * RING_DEPTH) + MEM_AW'(slot);
  assign rd_addr = MEM_AW'(int'(k_idx) * RING_DEPTH) + MEM_AW'(cur_head);

  // Update the addressed key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEYS_USED; i++) begin
        state_q[i] <= kcc_pkg::ST_IDLE;
        hold_q[i]  <= '0;
        gap_q[i]   <= '0;
        flag_q[i]  <= 1'b0;
        head_q[i]  <= '0;
        fill_q[i]  <= '0;
      end
    end else if (fire && cmd_i.hit) begin
      if (!cmd_i.pop) begin
        state_q[k_idx] <= n_st;
        hold_q[k_idx]  <= n_hold;
        gap_q[k_idx]   <= n_gap;
        flag_q[k_idx]  <= n_flag;
      end
      head_q[k_idx] <= n_head;
      fill_q[k_idx] <= n_fill;
    end
  end

  // Event ring: write on record unless full, registered read on pop
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= rec_ev;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // Output register: load on fire, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_key_q <= cmd_i.key;
      out_ev_q  <= pop_hit;
      if (cmd_i.hit) begin
        out_pend_q  <= kcc_pkg::PENDING_W'(n_fill);
        out_state_q <= cmd_i.pop ? cur_st : n_st;
      end else begin
        out_pend_q  <= '0;
        out_state_q <= kcc_pkg::ST_IDLE;
      end
    end
  end

  assign res.valid         = out_valid_q;
  assign res.key_index_out = out_key_q;
  assign res.event_valid   = out_ev_q;
  assign res.event_code    = out_ev_q ? rd_data_q : 2'd0;
  assign res.pending_count = out_pend_q;
  assign res.click_state   = out_state_q;

endmodule

/* hdl/key_click_classifier.sv */
// Top level of the key click classifier: configuration registers, front end,
// back end and checks. Depends on kcc_pkg, kcc_if, kcc_front and kcc_back.
//
//   port    dir  carries
//   in_i    in   opcode, key_index, key_down
//   out_o   out  key_index_out, event_valid, event_code, pending_count, click_state
//   cfg_i   in   index, data (always ready)
//
// One request per cycle sustained while out_o.ready stays high; a result passes from
// the command queue through the execute stage into the output register. The per-key
// table update and ring access happen in that back-end execute stage.
// Reset clears all per-key state at once; ring entries are undefined until written.
// A stalled output holds its register; the two-entry queue then fills and in_i.ready drops.
`timescale 1ns / 1ps
module key_click_classifier #(
  parameter int NUM_KEYS   = kcc_pkg::NUM_KEYS_DEF,
  parameter int RING_DEPTH = kcc_pkg::RING_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kcc_req_if.sink   in_i,
  kcc_res_if.source out_o,
  kcc_cfg_if.sink   cfg_i
);

  kcc_pkg::cfg_t cfg_q;
  logic          cmd_valid;
  logic          cmd_ready;
  kcc_pkg::cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_step        <= 8'd10;
      cfg_q.confirm_hold     <= 16'd20;
      cfg_q.long_hold        <= 16'd1000;
      cfg_q.double_click_gap <= 16'd200;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        kcc_pkg::CFG_TICK_STEP:  cfg_q.tick_step        <= cfg_i.data[7:0];
        kcc_pkg::CFG_CONFIRM:    cfg_q.confirm_hold     <= cfg_i.data;
        kcc_pkg::CFG_LONG_PRESS: cfg_q.long_hold        <= cfg_i.data;
        kcc_pkg::CFG_DOUBLE_GAP: cfg_q.double_click_gap <= cfg_i.data;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  kcc_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  kcc_back #(
    .NUM_KEYS   (NUM_KEYS),
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res         (out_o)
  );

  // A result without a popped event carries code zero
  a_no_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.event_valid) |-> (out_o.event_code == 2'd0))
    else $error("event code set without a popped event");

  // A popped event is one of the three click events
  a_event_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_valid) |->
      (out_o.event_code == kcc_pkg::EV_SHORT || out_o.event_code == kcc_pkg::EV_DOUBLE ||
       out_o.event_code == kcc_pkg::EV_LONG))
    else $error("popped event code is not a click event");

  // A key beyond the key count reports an empty idle key
  a_unused_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (int'(out_o.key_index_out) >= NUM_KEYS)) |->
      (!out_o.event_valid && out_o.pending_count == '0 && out_o.click_state == 3'd0))
    else $error("result for an unused key is not empty");

  // Nothing leaves the output register before a command reached the back end
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd_valid))
    else $error("result appeared without a queued command");

endmodule

/* bench/tb_key_click_classifier.sv */
// Self-checking bench for key_click_classifier: drives scan and pop requests, predicts
// each result from its own per-key click tracker and compares every field.
// Depends on kcc_pkg, kcc_if and the key_click_classifier RTL.
`timescale 1ns / 1ps
module tb_key_click_classifier;

  localparam int KEYS       = 8;
  localparam int RING       = 4;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [2:0] key;
    logic       ev_valid;
    logic [1:0] ev_code;
    logic [2:0] pending;
    logic [2:0] state;
  } click_report_t;

  logic clk;
  logic rst_n;

  kcc_req_if req_if ();
  kcc_res_if res_if ();
  kcc_cfg_if cfg_if ();

  key_click_classifier dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Threshold copies
  logic [7:0]  tick_step_q;
  logic [15:0] confirm_q;
  logic [15:0] long_hold_q;
  logic [15:0] dbl_gap_q;

  // Per-key tracker state
  kcc_pkg::click_state_e state_q [KEYS];
  logic [15:0]           hold_q  [KEYS];
  logic [15:0]           gap_q   [KEYS];
  logic                  flag_q  [KEYS];
  kcc_pkg::click_event_e ring_q  [KEYS][RING];
  logic [1:0]            head_q  [KEYS];
  logic [2:0]            fill_q  [KEYS];

  click_report_t click_reports_q[$];

  // Stimulus shaping
  int   send_idle_pct;
  int   recv_stall_pct;
  logic level_q  [KEYS];
  int   run_left [KEYS];
  int   errors;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void queue_click(logic [2:0] k, kcc_pkg::click_event_e ev);
    logic [1:0] slot;
    // drop when the ring is full
    if (fill_q[k] < RING) begin
      slot = 2'(head_q[k] + fill_q[k]);
      ring_q[k][slot] = ev;
      fill_q[k]++;
    end
  endfunction

  function automatic void advance_key(logic [2:0] k, logic down);
    if (down) hold_q[k] = sat_add(hold_q[k], tick_step_q);
    case (state_q[k])
      kcc_pkg::ST_IDLE: begin
        if (!down) hold_q[k] = '0;
        else state_q[k] = kcc_pkg::ST_MAYBE;
      end
      kcc_pkg::ST_MAYBE: begin
        if (!flag_q[k]) begin
          if (!down) state_q[k] = kcc_pkg::ST_IDLE;
          else if (hold_q[k] >= confirm_q) state_q[k] = kcc_pkg::ST_PRESSED;
        end else if (!down) begin
          // second press released early: the sticky flag path reports short
          state_q[k] = kcc_pkg::ST_PRESSED;
          queue_click(k, kcc_pkg::EV_SHORT);
        end else if (hold_q[k] >= confirm_q) begin
          state_q[k] = kcc_pkg::ST_DOUBLE;
          hold_q[k]  = '0;
          flag_q[k]  = 1'b0;
          queue_click(k, kcc_pkg::EV_DOUBLE);
        end
      end
      kcc_pkg::ST_PRESSED: begin
        if (!down) begin
          state_q[k] = kcc_pkg::ST_MAYBE_DBL;
          hold_q[k]  = '0;
          gap_q[k]   = '0;
        end else if (hold_q[k] >= long_hold_q) begin
          state_q[k] = kcc_pkg::ST_LONG;
        end
      end
      kcc_pkg::ST_MAYBE_DBL: begin
        if (!down) begin
          gap_q[k] = sat_add(gap_q[k], tick_step_q);
          if (gap_q[k] >= dbl_gap_q) begin
            state_q[k] = kcc_pkg::ST_IDLE;
            hold_q[k]  = '0;
            gap_q[k]   = '0;
            queue_click(k, kcc_pkg::EV_SHORT);
          end
        end else begin
          state_q[k] = kcc_pkg::ST_MAYBE;
          flag_q[k]  = 1'b1;
        end
      end
      kcc_pkg::ST_DOUBLE: begin
        if (!down) state_q[k] = kcc_pkg::ST_IDLE;
      end
      kcc_pkg::ST_LONG: begin
        if (!down) begin
          state_q[k] = kcc_pkg::ST_IDLE;
          hold_q[k]  = '0;
          queue_click(k, kcc_pkg::EV_LONG);
        end
      end
      default: ;
    endcase
  endfunction

  // Work out the result of one accepted request and advance the tracker
  function automatic click_report_t classify(kcc_pkg::opcode_e op, logic [2:0] k,
                                             logic down);
    click_report_t r;
    r.key      = k;
    r.ev_valid = 1'b0;
    r.ev_code  = kcc_pkg::EV_SHORT;
    if (op == kcc_pkg::OP_SCAN) begin
      advance_key(k, down);
    end else if (fill_q[k] > 0) begin
      r.ev_valid = 1'b1;
      r.ev_code  = ring_q[k][head_q[k]];
      fill_q[k]--;
      head_q[k]++;
    end
    r.pending = fill_q[k];
    r.state   = state_q[k];
    return r;
  endfunction

  function automatic void apply_setting(kcc_pkg::cfg_reg_e idx, logic [15:0] val);
    case (idx)
      kcc_pkg::CFG_TICK_STEP:  tick_step_q = val[7:0];
      kcc_pkg::CFG_CONFIRM:    confirm_q   = val;
      kcc_pkg::CFG_LONG_PRESS: long_hold_q = val;
      kcc_pkg::CFG_DOUBLE_GAP: dbl_gap_q   = val;
      default: ;
    endcase
  endfunction

  task automatic send_request(kcc_pkg::opcode_e op, logic [2:0] k, logic down);
    // idle the request channel at random
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
    @(negedge clk);
    req_if.valid     = 1'b1;
    req_if.opcode    = op;
    req_if.key_index = k;
    req_if.key_down  = down;
    do @(posedge clk); while (!req_if.ready);
    click_reports_q.push_back(classify(op, k, down));
  endtask

  // Hold off requests until every result has come back
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (click_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(kcc_pkg::cfg_reg_e idx, logic [15:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
    apply_setting(idx, val);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic program_thresholds(logic [7:0] step, logic [15:0] confirm,
                                    logic [15:0] long_press, logic [15:0] gap);
    wait_drained();
    write_reg(kcc_pkg::CFG_TICK_STEP, {8'h00, step});
    write_reg(kcc_pkg::CFG_CONFIRM, confirm);
    write_reg(kcc_pkg::CFG_LONG_PRESS, long_press);
    write_reg(kcc_pkg::CFG_DOUBLE_GAP, gap);
  endtask

  // Short, double and long clicks, the sticky second-press path and empty pops
  task automatic test_directed_events();
    program_thresholds(8'd100, 16'd100, 16'd300, 16'd100);
    // short click on the top key, then pop it
    send_request(kcc_pkg::OP_SCAN, 3'd7, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd7, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd7, 1'b0);
    send_request(kcc_pkg::OP_SCAN, 3'd7, 1'b0);
    send_request(kcc_pkg::OP_POP, 3'd7, 1'b0);
    // double click
    send_request(kcc_pkg::OP_SCAN, 3'd0, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd0, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd0, 1'b0);
    send_request(kcc_pkg::OP_SCAN, 3'd0, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd0, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd0, 1'b0);
    // long press
    send_request(kcc_pkg::OP_SCAN, 3'd1, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd1, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd1, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd1, 1'b0);
    // second press released before it is stable: short, flag stays set
    send_request(kcc_pkg::OP_SCAN, 3'd2, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd2, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd2, 1'b0);
    send_request(kcc_pkg::OP_SCAN, 3'd2, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd2, 1'b0);
    // pops, two with the level bit set, the last on an empty ring
    send_request(kcc_pkg::OP_POP, 3'd0, 1'b1);
    send_request(kcc_pkg::OP_POP, 3'd1, 1'b0);
    send_request(kcc_pkg::OP_POP, 3'd2, 1'b0);
    send_request(kcc_pkg::OP_POP, 3'd2, 1'b1);
  endtask

  // Hold a key long enough that the hold timer clips at its maximum
  task automatic test_hold_saturation();
    int i;
    program_thresholds(8'd254, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (i = 0; i < 260; i++) send_request(kcc_pkg::OP_SCAN, 3'd3, 1'b1);
    send_request(kcc_pkg::OP_SCAN, 3'd3, 1'b0);
    send_request(kcc_pkg::OP_POP, 3'd3, 1'b0);
  endtask

  // Press and release runs per key with random lengths, plus noise and pops
  task automatic test_random_sequences(int n_items, logic [2:0] focus, int max_run);
    int         i;
    int         roll;
    logic [2:0] k;
    for (i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      if ($urandom_range(0, 99) < 70) k = 3'(focus + $urandom_range(0, 1));
      else k = 3'($urandom_range(0, KEYS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_request(kcc_pkg::OP_POP, k, 1'($urandom_range(0, 1)));
      end else if (roll < 25) begin
        send_request(kcc_pkg::OP_SCAN, k, 1'($urandom_range(0, 1)));
      end else begin
        if (run_left[k] == 0) begin
          level_q[k]  = ~level_q[k];
          run_left[k] = $urandom_range(1, max_run);
        end
        run_left[k]--;
        send_request(kcc_pkg::OP_SCAN, k, level_q[k]);
      end
    end
  endtask

  // Result ready with random stalls
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    click_report_t want;
    click_report_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.key      = res_if.key_index_out;
      got.ev_valid = res_if.event_valid;
      got.ev_code  = res_if.event_code;
      got.pending  = res_if.pending_count;
      got.state    = res_if.click_state;
      if (click_reports_q.size() == 0) begin
        $error("result with no request outstanding: key %0d", got.key);
        errors++;
      end else begin
        want = click_reports_q.pop_front();
        if (got.key !== want.key) begin
          $error("key_index_out: expected %0d, got %0d", want.key, got.key);
          errors++;
        end
        if (got.ev_valid !== want.ev_valid) begin
          $error("event_valid: expected %0d, got %0d", want.ev_valid, got.ev_valid);
          errors++;
        end
        if (got.ev_code !== want.ev_code) begin
          $error("event_code: expected %0d, got %0d", want.ev_code, got.ev_code);
          errors++;
        end
        if (got.pending !== want.pending) begin
          $error("pending_count: expected %0d, got %0d", want.pending, got.pending);
          errors++;
        end
        if (got.state !== want.state) begin
          $error("click_state: expected %0d, got %0d", want.state, got.state);
          errors++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("key_click_classifier test failed");
      $finish;
    end
  end

  initial begin
    int k;
    errors           = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 12;
    recv_stall_pct   = 80;
    req_if.valid     = 1'b0;
    req_if.opcode    = kcc_pkg::OP_SCAN;
    req_if.key_index = '0;
    req_if.key_down  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = kcc_pkg::CFG_TICK_STEP;
    cfg_if.data      = '0;
    tick_step_q      = 8'd10;
    confirm_q        = 16'd20;
    long_hold_q      = 16'd1000;
    dbl_gap_q        = 16'd200;
    for (k = 0; k < KEYS; k++) begin
      state_q[k]  = kcc_pkg::ST_IDLE;
      hold_q[k]   = '0;
      gap_q[k]    = '0;
      flag_q[k]   = 1'b0;
      head_q[k]   = '0;
      fill_q[k]   = '0;
      level_q[k]  = 1'b0;
      run_left[k] = 0;
    end
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_hold_saturation();
    program_thresholds(8'd10, 16'd20, 16'd100, 16'd40);
    test_random_sequences(88, 3'd0, 14);

    send_idle_pct  = 80;
    recv_stall_pct = 12;
    program_thresholds(8'd255, 16'd0, 16'd1000, 16'd0);
    test_random_sequences(88, 3'd3, 6);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    program_thresholds(8'd1, 16'd2, 16'd0, 16'd3);
    test_random_sequences(88, 3'd6, 5);

    wait_drained();
    repeat (10) @(posedge clk);
    if (click_reports_q.size() != 0) begin
      $error("%0d results never arrived", click_reports_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("key_click_classifier test passed");
    end else begin
      $display("key_click_classifier test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/kcc_pkg.sv
hdl/kcc_if.sv
hdl/kcc_front.sv
hdl/kcc_back.sv
hdl/key_click_classifier.sv
bench/tb_key_click_classifier.sv
